// ----- sv/tch_pkg.sv -----
// Package of the tilt-compensated heading block: payload structs, widths and the
// arctangent constants of the CORDIC steps. Depends on nothing.
package tch_pkg;

    // Default configuration of the top level.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    // Operand width of the CORDIC input, the square root width and the
    // exponent of the normalised magnitude window.
    localparam int CW         = 48;
    localparam int SQ_W       = 40;
    localparam int SQ_OUT_W   = SQ_W / 2;
    localparam int NORM_EXP   = 40;
    localparam int LAT_BASE   = 10 + SQ_OUT_W;

    localparam logic signed [15:0] HALF_PI_BAM = 16'sd16384;

    typedef struct packed {
        logic signed [11:0] accel_x;
        logic signed [11:0] accel_y;
        logic signed [11:0] accel_z;
        logic signed [11:0] mag_x;
        logic signed [11:0] mag_y;
        logic signed [11:0] mag_z;
    } t_in_s;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] heading_angle;
    } t_out_s;

    // One atan2 request: operands and a flag that forces the angle to +pi/2.
    typedef struct packed {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
        logic                 force_hp;
    } t_cord_in;

    // atan(2^-i) in units of 2^-32 of a full turn.
    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Step angle rounded to the given number of angle bits.
    function automatic logic [31:0] atan_step(input int i, input int ab);
        logic [63:0] a;
        a = {32'h0, atan_turn32(i)} + (64'd1 << (31 - ab));
        return 32'(a >> (32 - ab));
    endfunction

endpackage

// ----- sv/tch_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on tch_pkg for the operand width.
module tch_sqrt
    import tch_pkg::*;
(
    input  logic                i_clk,
    input  logic [SQ_W-1:0]     i_n,
    output logic [SQ_OUT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_n   [1:SQ_OUT_W];
    logic [SQ_W-1:0] r_res [1:SQ_OUT_W];

    // Each stage tries one root bit against the running remainder.
    for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] n_in;
        logic [SQ_W-1:0] res_in;
        logic [SQ_W-1:0] n_trial;
        if (k == 0) begin : g_first
            assign n_in   = i_n;
            assign res_in = '0;
        end else begin : g_next
            assign n_in   = r_n[k];
            assign res_in = r_res[k];
        end
        assign n_trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (n_in >= n_trial) begin
                r_n[k+1]   <= n_in - n_trial;
                r_res[k+1] <= (res_in >> 1) + BIT;
            end else begin
                r_n[k+1]   <= n_in;
                r_res[k+1] <= res_in >> 1;
            end
        end
    end

    assign o_root = r_res[SQ_OUT_W][SQ_OUT_W-1:0];

endmodule

// ----- sv/tch_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) as a 16-bit binary angle.
// Depends on tch_pkg for the request struct and the step angle constants.
module tch_cordic
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cord_in           i_req,
    output logic               o_valid,
    output logic signed [15:0] o_angle
);

    localparam int W  = 45;
    localparam int NS = CORDIC_STEPS;
    localparam int PW = $clog2(CW);

    // Front end: magnitude, shift search, shift, half-turn fold.
    logic                 r_v0, r_v1, r_v2;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [CW-1:0]        r_m0;
    logic                 r_f0, r_f1, r_f2, r_z1, r_z2;
    logic                 r_right1;
    logic [PW-1:0]        r_sh1;
    logic signed [W-1:0]  r_x2, r_y2;

    logic signed [W-1:0]      r_x [0:NS];
    logic signed [W-1:0]      r_y [0:NS];
    logic [ANGLE_BITS-1:0]    r_z [0:NS];
    logic                     r_v [0:NS];
    logic                     r_zr [0:NS];
    logic                     r_f [0:NS];

    logic                     r_ov;
    logic signed [15:0]       r_angle;

    logic [CW-1:0]        ax_abs, ay_abs;
    logic [PW-1:0]        pos;
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [15:0]   bam;

    assign ax_abs = i_req.x[CW-1] ? CW'(-i_req.x) : CW'(i_req.x);
    assign ay_abs = i_req.y[CW-1] ? CW'(-i_req.y) : CW'(i_req.y);

    // Position of the leading one of the larger magnitude.
    always_comb begin
        pos = '0;
        for (int k = 0; k < CW; k++) begin
            if (r_m0[k]) begin
                pos = PW'(k);
            end
        end
    end

    // Normalise so that the larger magnitude lies in the window.
    always_comb begin
        if (r_right1) begin
            x_sh = r_x1 >>> r_sh1;
            y_sh = r_y1 >>> r_sh1;
        end else begin
            x_sh = r_x1 <<< r_sh1;
            y_sh = r_y1 <<< r_sh1;
        end
    end

    // Valid bits of the front end and the steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v[0] <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v[0] <= r_v2;
            r_ov <= r_v[NS];
        end
    end

    // Front end payload.
    always_ff @(posedge i_clk) begin
        r_x0 <= i_req.x;
        r_y0 <= i_req.y;
        r_f0 <= i_req.force_hp;
        r_m0 <= (ax_abs > ay_abs) ? ax_abs : ay_abs;

        r_x1 <= r_x0;
        r_y1 <= r_y0;
        r_f1 <= r_f0;
        r_z1 <= (r_m0 == '0);
        if (pos > PW'(NORM_EXP)) begin
            r_right1 <= 1'b1;
            r_sh1    <= pos - PW'(NORM_EXP);
        end else begin
            r_right1 <= 1'b0;
            r_sh1    <= PW'(NORM_EXP) - pos;
        end

        r_x2 <= x_sh[W-1:0];
        r_y2 <= y_sh[W-1:0];
        r_f2 <= r_f1;
        r_z2 <= r_z1;

        // A vector in the left half plane is turned by a half turn first.
        if (r_x2 < 0) begin
            r_x[0] <= -r_x2;
            r_y[0] <= -r_y2;
            r_z[0] <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
        end else begin
            r_x[0] <= r_x2;
            r_y[0] <= r_y2;
            r_z[0] <= '0;
        end
        r_f[0]  <= r_f2;
        r_zr[0] <= r_z2;
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic [ANGLE_BITS-1:0] T = ANGLE_BITS'(atan_step(i, ANGLE_BITS));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + T;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - T;
            end
            r_f[i+1]  <= r_f[i];
            r_zr[i+1] <= r_zr[i];
        end
    end

    // Scale the wrapped angle to 16 bits.
    if (ANGLE_BITS >= 16) begin : g_down
        logic signed [ANGLE_BITS-1:0] zs;
        assign zs  = $signed(r_z[NS]) >>> (ANGLE_BITS - 16);
        assign bam = zs[15:0];
    end else begin : g_up
        assign bam = $signed({r_z[NS], {(16 - ANGLE_BITS){1'b0}}});
    end

    // Output register with the forced and zero-vector cases.
    always_ff @(posedge i_clk) begin
        if (r_f[NS]) begin
            r_angle <= HALF_PI_BAM;
        end else if (r_zr[NS]) begin
            r_angle <= '0;
        end else begin
            r_angle <= bam;
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_angle;

endmodule

// ----- sv/tilt_compensated_heading.sv -----
// Top level of the tilt-compensated heading block: products, square roots,
// rotation terms and three CORDIC pipelines. Depends on tch_pkg, tch_sqrt
// and tch_cordic.
//
// Usage: drive a sample set of six accelerometer and magnetometer axes on
// i_item and raise start; the transfer takes place at a rising edge with
// start high and busy low. busy is always low, so a new sample set may be
// given in every cycle.
// Each sample set yields one result on o_result, shown for exactly one cycle
// with o_strobe high. Its path runs through the product stages, the 20 stages
// of the square root, the rotation stages and one stage per CORDIC step.
// Throughput is one sample set per cycle; results leave in input order.
// The receiver cannot stall the block and must take each result as shown.
// A synchronous reset on i_rst_n clears every valid bit, so no result is
// shown for sample sets in flight at reset.
module tilt_compensated_heading
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  t_in_s  i_item,
    output logic   busy,
    output logic   o_strobe,
    output t_out_s o_result
);

    // Side data that travels alongside the square roots.
    typedef struct packed {
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] az;
        logic signed [11:0] mx;
        logic signed [11:0] my;
        logic signed [11:0] mz;
        logic signed [25:0] d1;
        logic signed [25:0] s1;
        logic [23:0]        r2;
        logic               both0;
        logic               az0;
    } t_side;

    logic  accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input stage.
    logic  r_v0;
    t_in_s r_in0;

    // Product stage.
    logic               r_v1, r_both1, r_az01;
    logic signed [11:0] r_ax1, r_ay1, r_az1, r_mx1, r_my1, r_mz1;
    logic [22:0]        r_ax2, r_ay2, r_az2;
    logic signed [24:0] r_mz_aye, r_my_aye;
    logic signed [23:0] r_my_az, r_mz_az;

    // Sum stage.
    logic        r_v2;
    t_side       r_s2;
    logic [23:0] r_q2;

    // Square root delay line.
    logic  r_sv [0:SQ_OUT_W-1];
    t_side r_sd [0:SQ_OUT_W-1];
    logic [SQ_OUT_W-1:0] rf, bigr;

    // Rotation stages.
    logic                r_vh1, r_vh2;
    t_side               r_h1;
    logic [SQ_OUT_W-1:0] r_rf1;
    logic signed [46:0]  r_num1;
    logic signed [36:0]  r_t1;
    logic signed [37:0]  r_t2;
    t_cord_in            r_cp, r_cr, r_ch;

    logic signed [12:0] aye;
    logic signed [38:0] den_diff;
    logic signed [CW-1:0] den;
    logic signed [CW-1:0] ax_neg;

    logic               vp, vr, vh;
    logic signed [15:0] pitch, roll, head;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vh1 <= 1'b0;
            r_vh2 <= 1'b0;
            for (int k = 0; k < SQ_OUT_W; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_sv[0] <= r_v2;
            for (int k = 1; k < SQ_OUT_W; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_vh1 <= r_sv[SQ_OUT_W-1];
            r_vh2 <= r_vh1;
        end
    end

    // With a zero z axis the roll is +pi/2 and the y axis enters as its magnitude.
    assign aye = (r_in0.accel_z == 0) ?
                 ((r_in0.accel_y < 0) ? -13'(r_in0.accel_y) : 13'(r_in0.accel_y)) :
                 13'(r_in0.accel_y);

    // Input, products and sums.
    always_ff @(posedge i_clk) begin
        r_in0 <= i_item;

        r_ax1    <= r_in0.accel_x;
        r_ay1    <= r_in0.accel_y;
        r_az1    <= r_in0.accel_z;
        r_mx1    <= r_in0.mag_x;
        r_my1    <= r_in0.mag_y;
        r_mz1    <= r_in0.mag_z;
        r_both1  <= (r_in0.accel_y == 0) && (r_in0.accel_z == 0);
        r_az01   <= (r_in0.accel_z == 0);
        r_ax2    <= 23'(unsigned'(24'(r_in0.accel_x * r_in0.accel_x)));
        r_ay2    <= 23'(unsigned'(24'(r_in0.accel_y * r_in0.accel_y)));
        r_az2    <= 23'(unsigned'(24'(r_in0.accel_z * r_in0.accel_z)));
        r_mz_aye <= 25'(r_in0.mag_z * aye);
        r_my_aye <= 25'(r_in0.mag_y * aye);
        r_my_az  <= 24'(r_in0.mag_y * r_in0.accel_z);
        r_mz_az  <= 24'(r_in0.mag_z * r_in0.accel_z);

        r_s2.ax    <= r_ax1;
        r_s2.ay    <= r_ay1;
        r_s2.az    <= r_az1;
        r_s2.mx    <= r_mx1;
        r_s2.my    <= r_my1;
        r_s2.mz    <= r_mz1;
        r_s2.both0 <= r_both1;
        r_s2.az0   <= r_az01;
        r_s2.r2    <= 24'(r_ay2) + 24'(r_az2);
        r_q2       <= 24'(r_ay2) + 24'(r_az2) + 24'(r_ax2);
        r_s2.d1    <= 26'(r_mz_aye) - 26'(r_my_az);
        r_s2.s1    <= 26'(r_my_aye) + 26'(r_mz_az);
    end

    // Magnitudes with eight fraction bits.
    tch_sqrt u_sqrt_r (
        .i_clk  (i_clk),
        .i_n    ({r_s2.r2, 16'h0}),
        .o_root (rf)
    );

    tch_sqrt u_sqrt_big (
        .i_clk  (i_clk),
        .i_n    ({r_q2, 16'h0}),
        .o_root (bigr)
    );

    // Side data waits for the square roots.
    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_s2;
        for (int k = 1; k < SQ_OUT_W; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    assign den_diff = 39'(r_t1) - 39'(r_t2);
    assign den      = CW'(den_diff) <<< 8;
    assign ax_neg   = -(CW'(r_h1.ax) <<< 8);

    // Rotation terms, then the three atan2 requests.
    always_ff @(posedge i_clk) begin
        r_h1   <= r_sd[SQ_OUT_W-1];
        r_rf1  <= rf;
        r_num1 <= 47'($signed({1'b0, bigr}) * r_sd[SQ_OUT_W-1].d1);
        r_t1   <= 37'(r_sd[SQ_OUT_W-1].mx * $signed({1'b0, r_sd[SQ_OUT_W-1].r2}));
        r_t2   <= 38'(r_sd[SQ_OUT_W-1].ax * r_sd[SQ_OUT_W-1].s1);

        r_cp.y        <= ax_neg;
        r_cp.x        <= CW'(r_rf1);
        r_cp.force_hp <= r_h1.both0;

        r_cr.y        <= CW'(r_h1.ay);
        r_cr.x        <= CW'(r_h1.az);
        r_cr.force_hp <= r_h1.az0;

        if (r_h1.both0) begin
            r_ch.y <= CW'(r_h1.mz);
            r_ch.x <= CW'(r_h1.my);
        end else begin
            r_ch.y <= CW'(r_num1);
            r_ch.x <= den;
        end
        r_ch.force_hp <= 1'b0;
    end

    tch_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vh2),
        .i_req   (r_cp),
        .o_valid (vp),
        .o_angle (pitch)
    );

    tch_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vh2),
        .i_req   (r_cr),
        .o_valid (vr),
        .o_angle (roll)
    );

    tch_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vh2),
        .i_req   (r_ch),
        .o_valid (vh),
        .o_angle (head)
    );

    // All three pipelines run in lock step.
    assign o_strobe                 = vp && vr && vh;
    assign o_result.pitch_angle     = pitch;
    assign o_result.roll_angle      = roll;
    assign o_result.heading_angle   = head;

endmodule

// ----- sv/tch_checker.sv -----
// Port-level checker of the tilt-compensated heading block and its bind.
// Depends on tch_pkg and the top level's ports.
module tch_checker
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   start,
    input t_in_s  i_item,
    input logic   busy,
    input logic   o_strobe,
    input t_out_s o_result
);

    localparam int LAT = LAT_BASE + CORDIC_STEPS;

    // Every transfer in yields a result after the fixed latency.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result missing after transfer");

    // No result appears without a transfer the latency before.
    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without transfer");

    // A flat accelerometer y-z plane forces pitch and roll to +pi/2.
    a_both_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.accel_y == 0 && i_item.accel_z == 0) |-> ##LAT
        (o_result.pitch_angle == HALF_PI_BAM && o_result.roll_angle == HALF_PI_BAM))
        else $error("pitch or roll not forced");

    // A zero z axis forces the roll to +pi/2.
    a_az_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.accel_z == 0) |-> ##LAT
        (o_result.roll_angle == HALF_PI_BAM))
        else $error("roll not forced");

endmodule

bind tilt_compensated_heading tch_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_tch_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
